/* src/multilevel_priority_ready_queue_core_macros.svh */
// Assertion macros shared by the ready queue RTL.
`ifndef MULTILEVEL_PRIORITY_READY_QUEUE_CORE_MACROS_SVH
`define MULTILEVEL_PRIORITY_READY_QUEUE_CORE_MACROS_SVH
`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define MPRQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// When the antecedent holds, the consequent must hold in the next cycle.
`define MPRQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MPRQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define MPRQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* src/mprq_pkg.sv */
// Types, sizes and codes shared by the ready queue modules.
`default_nettype none

package mprq_pkg;

    // Sizes of the queue.
    localparam int LEVELS  = 8;
    localparam int PROCS   = 16;
    localparam int LEVEL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int PROC_W  = (PROCS > 1) ? $clog2(PROCS) : 1;

    // Internal index types.
    typedef logic [LEVEL_W-1:0] level_idx_t;
    typedef logic [PROC_W-1:0]  proc_idx_t;

    // Field types of the request and result.
    typedef logic [1:0] req_code_t;
    typedef logic [1:0] status_code_t;
    typedef logic [3:0] proc_fld_t;
    typedef logic [2:0] prio_fld_t;
    typedef logic [3:0] top_lvl_t;

    // Request codes.
    localparam req_code_t REQ_ENQUEUE = 2'd0;
    localparam req_code_t REQ_DEQUEUE = 2'd1;
    localparam req_code_t REQ_REMOVE  = 2'd2;
    localparam req_code_t REQ_QUERY   = 2'd3;

    // Status codes.
    localparam status_code_t ST_DONE   = 2'd0;
    localparam status_code_t ST_EMPTY  = 2'd1;
    localparam status_code_t ST_DUP    = 2'd2;
    localparam status_code_t ST_ABSENT = 2'd3;

    // Top level reported when every level is empty.
    localparam top_lvl_t TOP_EMPTY = top_lvl_t'(LEVELS);

    // One request.
    typedef struct packed {
        req_code_t req_type;
        proc_fld_t proc_id;
        prio_fld_t prio_level;
    } req_t;

    // One result.
    typedef struct packed {
        status_code_t status;
        proc_fld_t    out_proc;
        logic         is_queued;
        top_lvl_t     top_level;
    } rsp_t;

    // Registered request handed to the list logic.
    typedef struct packed {
        logic valid;
        req_t req;
    } cmd_t;

endpackage

`default_nettype wire

/* src/mprq_prio_enc.sv */
// Priority encoder that finds the lowest-numbered non-empty level.
`default_nettype none

module mprq_prio_enc (
    input  wire logic [mprq_pkg::LEVELS-1:0] nonempty,
    output mprq_pkg::level_idx_t             idx,
    output logic                             any
);

    // Scan from the least urgent level down so the most urgent one wins.
    always_comb
    begin
        idx = '0;
        for (int i = mprq_pkg::LEVELS - 1; i >= 0; i--)
        begin
            if (nonempty[i])
            begin
                idx = mprq_pkg::level_idx_t'(i);
            end
        end
    end

    assign any = |nonempty;

endmodule

`default_nettype wire

/* src/mprq_lists.sv */
// Per-level linked lists of processes, updated by one request per cycle.
`default_nettype none
`include "multilevel_priority_ready_queue_core_macros.svh"

module mprq_lists (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire mprq_pkg::cmd_t cmd,
    output mprq_pkg::rsp_t      rsp
);

    // List storage. Only the valid bits are reset.
    logic [mprq_pkg::LEVELS-1:0] nonempty_reg, nonempty_next;
    logic [mprq_pkg::PROCS-1:0]  queued_flag_reg, queued_flag_next;
    mprq_pkg::proc_idx_t  head_reg      [mprq_pkg::LEVELS];
    mprq_pkg::proc_idx_t  tail_reg      [mprq_pkg::LEVELS];
    mprq_pkg::proc_idx_t  next_link_reg [mprq_pkg::PROCS];
    mprq_pkg::proc_idx_t  prev_link_reg [mprq_pkg::PROCS];
    mprq_pkg::level_idx_t held_level_reg[mprq_pkg::PROCS];

    // Request decode.
    logic                 pid_ok;
    logic                 p_queued;
    mprq_pkg::proc_idx_t  p_idx;
    mprq_pkg::level_idx_t enq_lv;
    mprq_pkg::level_idx_t top_idx;
    logic                 top_any;
    mprq_pkg::level_idx_t lv;
    mprq_pkg::proc_idx_t  u_idx;
    logic                 do_append;
    logic                 do_unlink;
    logic                 is_deq;

    // Values read from the lists.
    mprq_pkg::proc_idx_t lv_head;
    mprq_pkg::proc_idx_t lv_tail;
    mprq_pkg::proc_idx_t u_next;
    mprq_pkg::proc_idx_t u_prev;
    logic                is_head;
    logic                is_tail;

    // Write ports.
    logic                 next_we, prev_we, head_we, tail_we, held_we;
    mprq_pkg::proc_idx_t  next_wa, next_wd, prev_wa, prev_wd, head_wd, tail_wd;

    // Level state after this request.
    mprq_pkg::level_idx_t top_next_idx;
    logic                 top_next_any;

    assign pid_ok   = int'(cmd.req.proc_id) < mprq_pkg::PROCS;
    assign p_idx    = pid_ok ? mprq_pkg::proc_idx_t'(cmd.req.proc_id) : '0;
    assign p_queued = pid_ok && queued_flag_reg[p_idx];
    assign enq_lv   = (int'(cmd.req.prio_level) >= mprq_pkg::LEVELS)
                    ? mprq_pkg::level_idx_t'(mprq_pkg::LEVELS - 1)
                    : mprq_pkg::level_idx_t'(cmd.req.prio_level);
    assign is_deq   = (cmd.req.req_type == mprq_pkg::REQ_DEQUEUE);

    // Most urgent level before the request, used by dequeue.
    mprq_prio_enc u_enc_cur (
        .nonempty (nonempty_reg),
        .idx      (top_idx),
        .any      (top_any)
    );

    // Select the level the request works on.
    always_comb
    begin
        unique case (cmd.req.req_type)
            mprq_pkg::REQ_ENQUEUE: lv = enq_lv;
            mprq_pkg::REQ_DEQUEUE: lv = top_idx;
            mprq_pkg::REQ_REMOVE:  lv = held_level_reg[p_idx];
            mprq_pkg::REQ_QUERY:   lv = held_level_reg[p_idx];
            default:               lv = held_level_reg[p_idx];
        endcase
    end

    // Dequeue unlinks the head of the top level, remove unlinks the given process.
    assign lv_head = head_reg[lv];
    assign lv_tail = tail_reg[lv];
    assign u_idx   = is_deq ? lv_head : p_idx;
    assign u_next  = next_link_reg[u_idx];
    assign u_prev  = prev_link_reg[u_idx];
    assign is_head = (lv_head == u_idx);
    assign is_tail = (lv_tail == u_idx);

    assign do_append = cmd.valid && (cmd.req.req_type == mprq_pkg::REQ_ENQUEUE)
                     && pid_ok && !p_queued;
    assign do_unlink = cmd.valid
                     && ((is_deq && top_any)
                         || ((cmd.req.req_type == mprq_pkg::REQ_REMOVE) && p_queued));

    // Write ports of the link and end tables.
    always_comb
    begin
        next_we = 1'b0;
        next_wa = lv_tail;
        next_wd = p_idx;
        prev_we = 1'b0;
        prev_wa = p_idx;
        prev_wd = lv_tail;
        head_we = 1'b0;
        head_wd = p_idx;
        tail_we = 1'b0;
        tail_wd = p_idx;
        held_we = do_append;
        nonempty_next    = nonempty_reg;
        queued_flag_next = queued_flag_reg;
        if (do_append)
        begin
            queued_flag_next[p_idx] = 1'b1;
            tail_we = 1'b1;
            if (nonempty_reg[lv])
            begin
                next_we = 1'b1;
                prev_we = 1'b1;
            end
            else
            begin
                head_we = 1'b1;
                nonempty_next[lv] = 1'b1;
            end
        end
        else if (do_unlink)
        begin
            queued_flag_next[u_idx] = 1'b0;
            priority if (is_head && is_tail)
            begin
                nonempty_next[lv] = 1'b0;
            end
            else if (is_head)
            begin
                head_we = 1'b1;
                head_wd = u_next;
            end
            else if (is_tail)
            begin
                tail_we = 1'b1;
                tail_wd = u_prev;
            end
            else
            begin
                next_we = 1'b1;
                next_wa = u_prev;
                next_wd = u_next;
                prev_we = 1'b1;
                prev_wa = u_next;
                prev_wd = u_prev;
            end
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nonempty_reg    <= '0;
            queued_flag_reg <= '0;
        end
        else
        begin
            nonempty_reg    <= nonempty_next;
            queued_flag_reg <= queued_flag_next;
        end
    end

    // Link and end tables, meaningful only under their valid bits.
    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_link_reg[next_wa] <= next_wd;
        end
        if (prev_we)
        begin
            prev_link_reg[prev_wa] <= prev_wd;
        end
        if (head_we)
        begin
            head_reg[lv] <= head_wd;
        end
        if (tail_we)
        begin
            tail_reg[lv] <= tail_wd;
        end
        if (held_we)
        begin
            held_level_reg[p_idx] <= lv;
        end
    end

    // Most urgent level after the request.
    mprq_prio_enc u_enc_next (
        .nonempty (nonempty_next),
        .idx      (top_next_idx),
        .any      (top_next_any)
    );

    // Result of the request.
    always_comb
    begin
        rsp.status = mprq_pkg::ST_DONE;
        unique case (cmd.req.req_type)
            mprq_pkg::REQ_ENQUEUE:
            begin
                if (p_queued)
                begin
                    rsp.status = mprq_pkg::ST_DUP;
                end
            end
            mprq_pkg::REQ_DEQUEUE:
            begin
                if (!top_any)
                begin
                    rsp.status = mprq_pkg::ST_EMPTY;
                end
            end
            mprq_pkg::REQ_REMOVE:
            begin
                if (!p_queued)
                begin
                    rsp.status = mprq_pkg::ST_ABSENT;
                end
            end
            mprq_pkg::REQ_QUERY:
            begin
                rsp.status = mprq_pkg::ST_DONE;
            end
            default:
            begin
                rsp.status = mprq_pkg::ST_DONE;
            end
        endcase
        rsp.out_proc  = (is_deq && top_any) ? mprq_pkg::proc_fld_t'(u_idx) : '0;
        rsp.is_queued = pid_ok && queued_flag_next[p_idx];
        rsp.top_level = top_next_any ? mprq_pkg::top_lvl_t'(top_next_idx)
                                     : mprq_pkg::TOP_EMPTY;
    end

    // Some process is queued exactly when some level is non-empty.
    `MPRQ_ASSERT(a_flags_agree, clk, rst_n, (|queued_flag_reg) == (|nonempty_reg), "queued flags and level bits disagree")
    // An accepted enqueue leaves the process queued.
    `MPRQ_ASSERT_NEXT(a_enq_sets, clk, rst_n, do_append, queued_flag_reg[$past(p_idx)], "enqueued process is not queued")
    // A dequeue from a non-empty queue leaves the taken process unqueued.
    `MPRQ_ASSERT_NEXT(a_deq_clears, clk, rst_n, do_unlink && is_deq, !queued_flag_reg[$past(u_idx)], "dequeued process is still queued")

endmodule

`default_nettype wire

/* src/multilevel_priority_ready_queue_core.sv */
// Top level of the multilevel priority ready queue.
//
// Usage:
//   A request (enqueue, dequeue, remove or query) is presented on req and
//   taken at a rising edge where start is high and busy is low. busy stays
//   low, so a request may be taken at every edge.
//   Each request gives one result on rsp, marked by done for exactly one
//   cycle. The receiver cannot stall: a result must be taken in that cycle.
// Pipeline and throughput:
//   A taken request is held in the input register, runs through the list
//   logic and is stored in the result register, which drives done and rsp.
//   One request per cycle is sustained. The cycle time is set by the
//   dequeue path: level priority encoder, head table read, link table
//   read and the head table write-back.
// Reset:
//   rst_n clears every level and every queued flag, so the queue starts
//   empty; no request or result is in flight after reset.
`default_nettype none
`include "multilevel_priority_ready_queue_core_macros.svh"

module multilevel_priority_ready_queue_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire mprq_pkg::req_t req,
    output logic                done,
    output mprq_pkg::rsp_t      rsp
);

    logic            req_valid_reg, req_valid_next;
    mprq_pkg::req_t  req_reg;
    logic            done_reg;
    mprq_pkg::rsp_t  rsp_reg, rsp_next;
    mprq_pkg::cmd_t  cmd;

    // The block takes a request in every cycle.
    assign busy           = 1'b0;
    assign req_valid_next = start && !busy;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid_next)
        begin
            req_reg <= req;
        end
    end

    assign cmd.valid = req_valid_reg;
    assign cmd.req   = req_reg;

    // List state and request logic.
    mprq_lists u_lists (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp_next)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    // An empty dequeue leaves every level empty.
    `MPRQ_ASSERT(a_empty_top, clk, rst_n, done_reg && (rsp_reg.status == mprq_pkg::ST_EMPTY) |-> rsp_reg.top_level == mprq_pkg::TOP_EMPTY, "empty dequeue with a non-empty level")
    // Only a successful dequeue reports a process.
    `MPRQ_ASSERT(a_proc_zero, clk, rst_n, done_reg && (rsp_reg.status != mprq_pkg::ST_DONE) |-> rsp_reg.out_proc == '0, "process reported on a failed request")
    // A duplicate enqueue means the process is queued somewhere.
    `MPRQ_ASSERT(a_dup_queued, clk, rst_n, done_reg && (rsp_reg.status == mprq_pkg::ST_DUP) |-> rsp_reg.is_queued && (rsp_reg.top_level != mprq_pkg::TOP_EMPTY), "duplicate enqueue of an unqueued process")

endmodule

`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for the multilevel priority ready queue core.
`timescale 1ns / 1ps

module tb;

    import mprq_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int RESET_CYCLES = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 8;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    logic done;
    rsp_t rsp;

    multilevel_priority_ready_queue_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    // Shadow copy of the ready queue lists.
    bit         level_busy  [LEVELS];
    proc_idx_t  level_first [LEVELS];
    proc_idx_t  level_last  [LEVELS];
    bit         proc_queued [PROCS];
    proc_idx_t  next_proc   [PROCS];
    proc_idx_t  prev_proc   [PROCS];
    level_idx_t proc_level  [PROCS];

    // Results still owed by the block, oldest first.
    rsp_t pending_rsp [$];

    int error_count;
    int results_checked;
    int req_count [4];
    int deepest_queue;
    int sender_idle_pct;

    // Focus window for random priorities, so that some levels build long lists.
    int level_base;
    int level_span;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Run limit in case the block stops answering.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("FAIL");
        $finish;
    end

    // Lowest non-empty level, or the empty marker when every level is empty.
    function automatic top_lvl_t first_busy_level();
        top_lvl_t top;
        top = TOP_EMPTY;
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            if (level_busy[i])
                top = top_lvl_t'(i);
        end
        return top;
    endfunction

    // Unlink one queued process from its level list.
    function automatic void unlink_proc(proc_idx_t p);
        level_idx_t lv;
        bit at_head;
        bit at_tail;
        lv = proc_level[p];
        at_head = (level_first[lv] == p);
        at_tail = (level_last[lv] == p);
        if (at_head && at_tail)
            level_busy[lv] = 1'b0;
        else if (at_head)
            level_first[lv] = next_proc[p];
        else if (at_tail)
            level_last[lv] = prev_proc[p];
        else
        begin
            next_proc[prev_proc[p]] = next_proc[p];
            prev_proc[next_proc[p]] = prev_proc[p];
        end
        proc_queued[p] = 1'b0;
    endfunction

    // Apply one request to the shadow lists and return the result it must give.
    function automatic rsp_t predict_ready_queue(req_t r);
        rsp_t res;
        proc_idx_t p;
        proc_idx_t head;
        level_idx_t lv;
        top_lvl_t top;
        p = proc_idx_t'(r.proc_id);
        res.status = ST_DONE;
        res.out_proc = '0;
        case (r.req_type)
            REQ_ENQUEUE:
            begin
                if (proc_queued[p])
                    res.status = ST_DUP;
                else
                begin
                    lv = level_idx_t'(r.prio_level);
                    if (level_busy[lv])
                    begin
                        next_proc[level_last[lv]] = p;
                        prev_proc[p] = level_last[lv];
                        level_last[lv] = p;
                    end
                    else
                    begin
                        level_first[lv] = p;
                        level_last[lv] = p;
                        level_busy[lv] = 1'b1;
                    end
                    proc_level[p] = lv;
                    proc_queued[p] = 1'b1;
                end
            end
            REQ_DEQUEUE:
            begin
                top = first_busy_level();
                if (top == TOP_EMPTY)
                    res.status = ST_EMPTY;
                else
                begin
                    head = level_first[level_idx_t'(top)];
                    unlink_proc(head);
                    res.out_proc = proc_fld_t'(head);
                end
            end
            REQ_REMOVE:
            begin
                if (proc_queued[p])
                    unlink_proc(p);
                else
                    res.status = ST_ABSENT;
            end
            default:
            begin
            end
        endcase
        res.is_queued = proc_queued[p];
        res.top_level = first_busy_level();
        return res;
    endfunction

    function automatic int queued_total();
        int n;
        n = 0;
        for (int i = 0; i < PROCS; i++)
            n += proc_queued[i];
        return n;
    endfunction

    function automatic req_t make_req(req_code_t kind, int pid, int prio);
        req_t r;
        r.req_type = kind;
        r.proc_id = proc_fld_t'(pid);
        r.prio_level = prio_fld_t'(prio);
        return r;
    endfunction

    // Present one request, hold it until taken, and record the expected result.
    task automatic send_request(input req_t r);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            req <= req_t'($urandom);
            @(negedge clk);
        end
        start <= 1'b1;
        req <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_rsp.push_back(predict_ready_queue(r));
        req_count[r.req_type]++;
        if (queued_total() > deepest_queue)
            deepest_queue = queued_total();
    endtask

    // Stop sending and wait for every outstanding result.
    task automatic wait_for_results();
        @(negedge clk);
        start <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
    endtask

    // Compare each result with the oldest expectation.
    always @(posedge clk)
    begin : check_results
        rsp_t want;
        if (rst_n && done)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("unexpected result: status %0d out_proc %0d is_queued %0d top_level %0d",
                       rsp.status, rsp.out_proc, rsp.is_queued, rsp.top_level);
                error_count++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                results_checked++;
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, rsp.status);
                    error_count++;
                end
                if (rsp.out_proc !== want.out_proc)
                begin
                    $error("out_proc: expected %0d, actual %0d", want.out_proc, rsp.out_proc);
                    error_count++;
                end
                if (rsp.is_queued !== want.is_queued)
                begin
                    $error("is_queued: expected %0d, actual %0d", want.is_queued,
                           rsp.is_queued);
                    error_count++;
                end
                if (rsp.top_level !== want.top_level)
                begin
                    $error("top_level: expected %0d, actual %0d", want.top_level,
                           rsp.top_level);
                    error_count++;
                end
            end
        end
    end

    // Requests against a queue that holds nothing.
    task automatic test_empty_queue();
        send_request(make_req(REQ_DEQUEUE, 0, 0));
        send_request(make_req(REQ_QUERY, 15, 7));
        send_request(make_req(REQ_REMOVE, 7, 0));
    endtask

    // Enqueues at both extreme levels, then duplicates of a head and of a tail.
    task automatic test_enqueue_duplicates();
        send_request(make_req(REQ_ENQUEUE, 0, 7));
        send_request(make_req(REQ_ENQUEUE, 15, 0));
        send_request(make_req(REQ_ENQUEUE, 5, 0));
        send_request(make_req(REQ_ENQUEUE, 9, 0));
        send_request(make_req(REQ_ENQUEUE, 15, 4));
        send_request(make_req(REQ_ENQUEUE, 9, 0));
        send_request(make_req(REQ_QUERY, 5, 0));
        send_request(make_req(REQ_QUERY, 3, 0));
    endtask

    // Removal from the middle, the tail and a lone entry, plus an absent target.
    task automatic test_remove_positions();
        send_request(make_req(REQ_REMOVE, 5, 0));
        send_request(make_req(REQ_REMOVE, 9, 0));
        send_request(make_req(REQ_REMOVE, 5, 0));
        send_request(make_req(REQ_REMOVE, 15, 0));
    endtask

    // FIFO order within a level and priority order across levels.
    task automatic test_dequeue_order();
        send_request(make_req(REQ_ENQUEUE, 1, 2));
        send_request(make_req(REQ_ENQUEUE, 2, 2));
        send_request(make_req(REQ_ENQUEUE, 3, 2));
        send_request(make_req(REQ_REMOVE, 1, 2));
        send_request(make_req(REQ_DEQUEUE, 2, 0));
        send_request(make_req(REQ_DEQUEUE, 3, 0));
        send_request(make_req(REQ_DEQUEUE, 0, 0));
        send_request(make_req(REQ_DEQUEUE, 0, 0));
    endtask

    // Pick a process that is queued (or not), falling back to any process.
    function automatic int pick_proc(bit want_queued);
        int cand [$];
        for (int i = 0; i < PROCS; i++)
        begin
            if (proc_queued[i] == want_queued)
                cand.push_back(i);
        end
        if (cand.size() == 0)
            return $urandom_range(PROCS - 1);
        return cand[$urandom_range(cand.size() - 1)];
    endfunction

    // Mostly purposeful requests against the current queue contents, some noise.
    function automatic req_t next_random_request();
        req_t r;
        int depth;
        int enq_pct;
        int roll;
        int prio;
        depth = queued_total();
        enq_pct = (depth < 4) ? 60 : (depth > 12) ? 20 : 40;
        prio = (level_base + $urandom_range(level_span - 1)) % LEVELS;
        if ($urandom_range(99) < 10)
            return req_t'($urandom);
        roll = $urandom_range(99);
        if (roll < enq_pct)
            r = make_req(REQ_ENQUEUE, pick_proc($urandom_range(99) >= 80), prio);
        else
        begin
            roll = $urandom_range(99);
            if (roll < 40)
                r = make_req(REQ_DEQUEUE, $urandom_range(PROCS - 1), $urandom_range(7));
            else if (roll < 80)
                r = make_req(REQ_REMOVE, pick_proc($urandom_range(99) < 80),
                             $urandom_range(7));
            else
                r = make_req(REQ_QUERY, pick_proc($urandom_range(1)), $urandom_range(7));
        end
        return r;
    endfunction

    // Random traffic, re-centering the priority window every few dozen requests.
    task automatic test_random_traffic(input int idle_pct, input int count);
        sender_idle_pct = idle_pct;
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
            begin
                level_base = $urandom_range(LEVELS - 1);
                level_span = $urandom_range(LEVELS, 1);
            end
            send_request(next_random_request());
        end
    endtask

    // Test sequence.
    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        error_count = 0;
        results_checked = 0;
        deepest_queue = 0;
        sender_idle_pct = 0;
        level_base = 0;
        level_span = LEVELS;
        for (int i = 0; i < 4; i++)
            req_count[i] = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_queue();
        test_enqueue_duplicates();
        test_remove_positions();
        test_dequeue_order();

        test_random_traffic(35, 300);
        wait_for_results();
        test_random_traffic(46, 300);
        wait_for_results();
        test_random_traffic(0, 300);
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Checked %0d results: %0d enqueue, %0d dequeue, %0d remove, %0d query.",
                 results_checked, req_count[REQ_ENQUEUE], req_count[REQ_DEQUEUE],
                 req_count[REQ_REMOVE], req_count[REQ_QUERY]);
        $display("Most processes queued at once: %0d of %0d; mismatches: %0d.",
                 deepest_queue, PROCS, error_count);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
